// ===== hw/rtl/chebyshev_clenshaw_evaluator_macros.svh =====
// ----------------------------------------------------------------------------
// Chebyshev Clenshaw evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_CLENSHAW_EVALUATOR_MACROS_SVH
`define CHEBYSHEV_CLENSHAW_EVALUATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CCE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cce_pkg.sv =====
// ----------------------------------------------------------------------------
// Chebyshev Clenshaw evaluator package
// Default sizes, register and kind codes, and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cce_pkg;

  localparam int CCE_MAX_TERMS = 32;
  localparam int CCE_NUM_SETS  = 4;
  localparam int CCE_FRAC_BITS = 16;

  localparam int DATA_W     = 32;
  localparam int SUM_W      = 66;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_SETS   = 4;
  localparam int OUT_TDATA_W = OUT_SETS * DATA_W;

  localparam logic [CFG_ADDR_W-1:0] REG_CENTER   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_HALF = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TERMS    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SETS     = 3'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  function automatic logic sat_ovf(input sum_t v);
    logic all_one;
    logic all_zero;
    all_one  = &v[SUM_W-1:DATA_W-1];
    all_zero = ~|v[SUM_W-1:DATA_W-1];
    return !(all_one || all_zero);
  endfunction

  function automatic word_t sat_val(input sum_t v);
    word_t r;
    if (sat_ovf(v)) begin
      r = v[SUM_W-1] ? word_t'({1'b1, {(DATA_W-1){1'b0}}}) :
                       word_t'({1'b0, {(DATA_W-1){1'b1}}});
    end else begin
      r = word_t'(v[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cce_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chebyshev_clenshaw_evaluator.sv =====
// A load transfer is written to the coefficient memory as it is accepted; an evaluate
// transfer runs the difference, scale and saturate steps, a multiply and an add step per
// term and set, then the done step. No new transfer is taken until the done step ends;
// one shared multiplier serves every step, as each Clenshaw step needs the previous sum.
// Reset: configuration returns to its defaults and the control clears; the
// coefficient memory is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// Chebyshev Clenshaw evaluator
// Evaluates up to four Chebyshev series at a mapped point in signed fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module chebyshev_clenshaw_evaluator #(
  parameter int MAX_TERMS = cce_pkg::CCE_MAX_TERMS,
  parameter int NUM_SETS  = cce_pkg::CCE_NUM_SETS,
  parameter int FRAC_BITS = cce_pkg::CCE_FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cce_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [cce_pkg::DATA_W-1:0]         cfg_wdata_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // set_index[1:0], coef_index[6:2], coef_value[38:7], x_value[70:39], zero[71]
  input  wire logic [cce_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // kind[0]
  input  wire logic                               s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // value_0[31:0], value_1[63:32], value_2[95:64], value_3[127:96]
  output logic [cce_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,
  // saturated[0]
  output logic                                    m_axis_tuser_o
);

  import cce_pkg::*;

  `include "chebyshev_clenshaw_evaluator_macros.svh"

  localparam int TERM_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int TCNT_W = $clog2(MAX_TERMS + 1);
  localparam int SCNT_W = $clog2(NUM_SETS + 1);
  localparam int RAM_AW = SET_W + TERM_W;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_YMUL = 3'd2;
  localparam logic [2:0] ST_YSAT = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  word_t      center_q;
  word_t      inv_half_q;
  logic [5:0] terms_q;
  logic [2:0] sets_q;

  word_t x_q, x_d;
  word_t diff_q, diff_d;
  word_t y_q, y_d;
  word_t dd_q, dd_d;
  word_t ddd_q, ddd_d;
  logic signed [2*DATA_W-1:0] prod_q, prod_d;
  logic [TERM_W-1:0] j_q, j_d;
  logic [SET_W-1:0]  set_q, set_d;
  logic sat_q, sat_d;
  word_t vals_q [NUM_SETS];
  word_t vals_d [NUM_SETS];

  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic                   m_sat_q, m_sat_d;

  logic [TCNT_W-1:0] terms_eff;
  logic [SCNT_W-1:0] sets_eff;
  logic [TERM_W-1:0] j_init;

  logic                      in_fire;
  logic [1:0]                in_set;
  logic [4:0]                in_coef_idx;
  word_t                     in_coef;
  word_t                     in_x;
  logic                      load_ok;
  logic                      ram_we;
  logic [RAM_AW-1:0]         ram_waddr;
  logic [RAM_AW-1:0]         ram_raddr;
  logic [DATA_W-1:0]         ram_rdata;

  word_t                      mul_a, mul_b;
  logic signed [2*DATA_W-1:0] prod_sh;
  sum_t                       step_sum;
  sum_t                       diff_sum;
  sum_t                       y_sum;
  word_t                      vals_all [OUT_SETS];

  assign in_set      = s_axis_tdata_i[1:0];
  assign in_coef_idx = s_axis_tdata_i[6:2];
  assign in_coef     = word_t'(s_axis_tdata_i[38:7]);
  assign in_x        = word_t'(s_axis_tdata_i[70:39]);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (terms_q == 6'd0) begin
      terms_eff = TCNT_W'(1);
    end else if (32'(terms_q) > 32'(MAX_TERMS)) begin
      terms_eff = TCNT_W'(MAX_TERMS);
    end else begin
      terms_eff = TCNT_W'(terms_q);
    end
    if (sets_q == 3'd0) begin
      sets_eff = SCNT_W'(1);
    end else if (32'(sets_q) > 32'(NUM_SETS)) begin
      sets_eff = SCNT_W'(NUM_SETS);
    end else begin
      sets_eff = SCNT_W'(sets_q);
    end
  end

  assign j_init = TERM_W'(32'(terms_eff) - 32'd1);

  assign load_ok = (32'(in_set) < 32'(NUM_SETS)) && (32'(in_coef_idx) < 32'(MAX_TERMS));
  assign ram_we    = in_fire && (s_axis_tuser_i == KIND_LOAD) && load_ok;
  assign ram_waddr = {SET_W'(in_set), TERM_W'(in_coef_idx)};
  assign ram_raddr = {set_q, j_q};

  cce_ram #(
    .WIDTH(DATA_W),
    .DEPTH(RAM_DEPTH)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_coef),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign mul_a = (state_q == ST_YMUL) ? diff_q : y_q;
  assign mul_b = (state_q == ST_YMUL) ? inv_half_q : dd_q;

  assign prod_sh  = (j_q == '0) ? (prod_q >>> FRAC_BITS) : (prod_q >>> (FRAC_BITS - 1));
  assign step_sum = SUM_W'(prod_sh) - SUM_W'(ddd_q) + SUM_W'($signed(ram_rdata));
  assign diff_sum = SUM_W'(x_q) - SUM_W'(center_q);
  assign y_sum    = SUM_W'(prod_q >>> FRAC_BITS);

  for (genvar k = 0; k < OUT_SETS; k++) begin : g_out
    if (k < NUM_SETS) begin : g_act
      assign vals_all[k] = vals_q[k];
    end else begin : g_zero
      assign vals_all[k] = '0;
    end
  end

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    diff_d    = diff_q;
    y_d       = y_q;
    dd_d      = dd_q;
    ddd_d     = ddd_q;
    prod_d    = prod_q;
    j_d       = j_q;
    set_d     = set_q;
    sat_d     = sat_q;
    vals_d    = vals_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_sat_d   = m_sat_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser_i == KIND_EVAL)) begin
          x_d     = in_x;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_d = sat_val(diff_sum);
        sat_d  = sat_ovf(diff_sum);
        for (int k = 0; k < NUM_SETS; k++) begin
          vals_d[k] = '0;
        end
        state_d = ST_YMUL;
      end
      ST_YMUL: begin
        prod_d  = mul_a * mul_b;
        state_d = ST_YSAT;
      end
      ST_YSAT: begin
        y_d     = sat_val(y_sum);
        sat_d   = sat_q | sat_ovf(y_sum);
        set_d   = '0;
        j_d     = j_init;
        dd_d    = '0;
        ddd_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = mul_a * mul_b;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        sat_d = sat_q | sat_ovf(step_sum);
        if (j_q == '0) begin
          vals_d[set_q] = sat_val(step_sum);
          if ((32'(set_q) + 32'd1) == 32'(sets_eff)) begin
            state_d = ST_DONE;
          end else begin
            set_d   = set_q + SET_W'(1);
            j_d     = j_init;
            dd_d    = '0;
            ddd_d   = '0;
            state_d = ST_MUL;
          end
        end else begin
          ddd_d   = dd_q;
          dd_d    = sat_val(step_sum);
          j_d     = j_q - TERM_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_sat_d   = sat_q;
          for (int k = 0; k < OUT_SETS; k++) begin
            m_data_d[k*DATA_W +: DATA_W] = vals_all[k];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      center_q   <= '0;
      inv_half_q <= word_t'(1 << FRAC_BITS);
      terms_q    <= 6'd32;
      sets_q     <= 3'd1;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_CENTER:   center_q   <= word_t'(cfg_wdata_i);
          REG_INV_HALF: inv_half_q <= word_t'(cfg_wdata_i);
          REG_TERMS:    terms_q    <= cfg_wdata_i[5:0];
          REG_SETS:     sets_q     <= cfg_wdata_i[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    diff_q   <= diff_d;
    y_q      <= y_d;
    dd_q     <= dd_d;
    ddd_q    <= ddd_d;
    prod_q   <= prod_d;
    j_q      <= j_d;
    set_q    <= set_d;
    sat_q    <= sat_d;
    vals_q   <= vals_d;
    m_data_q <= m_data_d;
    m_sat_q  <= m_sat_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_sat_q;

  `CCE_ASSERT_NEXT(a_eval_starts, in_fire && (s_axis_tuser_i == KIND_EVAL), state_q == ST_DIFF, "evaluate transfer did not start the sequence")
  `CCE_ASSERT_NEXT(a_load_stays, in_fire && (s_axis_tuser_i == KIND_LOAD), state_q == ST_IDLE, "load transfer left idle")
  `CCE_ASSERT_SAME(a_result_from_done, $rose(m_valid_q), $past(state_q) == ST_DONE, "result appeared outside the done step")
  `CCE_ASSERT_SAME(a_term_in_range, state_q == ST_MUL, (32'(j_q) < 32'(terms_eff)) && (32'(set_q) < 32'(sets_eff)), "term or set counter out of range")

endmodule

`default_nettype wire
